/* hw/rtl/fk_pkg.sv */
package fk_pkg;

  localparam int AngW   = 16;
  localparam int TrigW  = 16;
  localparam int LenW   = 20;
  localparam int RotW   = 16;
  localparam int PosW   = 22;
  localparam int NumJoints = 6;
  localparam int NumTrig   = 12;
  localparam int NumRot    = 9;
  localparam int NumPos    = 3;

  // Pipeline depth of one sine lane and of the merging stage.
  localparam int SinLatency   = 9;
  localparam int MergeLatency = 6;
  localparam int FkLatency    = SinLatency + MergeLatency;

  localparam logic [AngW-1:0] QuarterTurn = 16'd16384;

  // Odd Taylor coefficients of sin(pi/2 * t) in Q2.30, highest power first.
  localparam logic [30:0] SinCoef [6] = '{
    31'd3864, 31'd172273, 31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
  };

  // Lane assignment of the sines and cosines.
  localparam int TrigS1   = 0;
  localparam int TrigC1   = 1;
  localparam int TrigS2   = 2;
  localparam int TrigC2   = 3;
  localparam int TrigS5   = 4;
  localparam int TrigC5   = 5;
  localparam int TrigS6   = 6;
  localparam int TrigC6   = 7;
  localparam int TrigS23  = 8;
  localparam int TrigC23  = 9;
  localparam int TrigS234 = 10;
  localparam int TrigC234 = 11;

  typedef enum logic [2:0] {
    CfgBaseHeight   = 3'd0,
    CfgShoulderOff  = 3'd1,
    CfgWristTwoOff  = 3'd2,
    CfgToolOff      = 3'd3,
    CfgUpperArmLen  = 3'd4,
    CfgForearmLen   = 3'd5
  } cfg_idx_e;

  localparam logic [LenW-1:0] ResetBaseHeight  = 20'd89352;
  localparam logic [LenW-1:0] ResetShoulderOff = 20'd110863;
  localparam logic [LenW-1:0] ResetWristTwoOff = 20'd94818;
  localparam logic [LenW-1:0] ResetToolOff     = 20'd82503;
  localparam logic [LenW-1:0] ResetUpperArmLen = 20'd425514;
  localparam logic [LenW-1:0] ResetForearmLen  = 20'd392277;

  typedef logic signed [TrigW-1:0] trig_t;
  typedef trig_t trig_vec_t [NumTrig];
  typedef logic signed [RotW-1:0] rot_t;
  typedef logic signed [PosW-1:0] pos_t;

  typedef struct packed {
    logic [LenW-1:0] base_height;
    logic [LenW-1:0] shoulder_off;
    logic [LenW-1:0] wrist_two_off;
    logic [LenW-1:0] tool_off;
    logic [LenW-1:0] upper_arm_len;
    logic [LenW-1:0] forearm_len;
  } len_cfg_t;

endpackage

/* hw/rtl/six_axis_arm_forward_kinematics_top.sv */
// An accepted item passes through the sine lanes and then the merging multipliers
// and adders before its pose reaches the output.
// Throughput: one item per cycle; the pipeline holds while a finished pose waits.
// Reset: asynchronous, active low; it empties the pipeline and loads the link
// lengths with their default values.
// Configuration writes are meant only while the pipeline is empty.
module six_axis_arm_forward_kinematics_top import fk_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port.
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  // Joint angles in.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // joint1_angle, joint2_angle, ..., joint6_angle, 16 bits each
  input  logic [95:0]  s_axis_tdata,
  // Pose out.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22
  // (16 bits each), pos_x_um, pos_y_um, pos_z_um (22 bits each), 6 zero bits
  output logic [215:0] m_axis_tdata
);

  // The whole pipeline moves as one; it stops only when the output holds a
  // pose that the sink has not yet taken.
  logic ce;
  logic [FkLatency-1:0] vld_q;

  assign ce            = ~vld_q[FkLatency-1] | m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld_q[FkLatency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[FkLatency-2:0], s_axis_tvalid};
    end
  end

  // Link lengths.
  len_cfg_t len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q.base_height   <= ResetBaseHeight;
      len_q.shoulder_off  <= ResetShoulderOff;
      len_q.wrist_two_off <= ResetWristTwoOff;
      len_q.tool_off      <= ResetToolOff;
      len_q.upper_arm_len <= ResetUpperArmLen;
      len_q.forearm_len   <= ResetForearmLen;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBaseHeight:  len_q.base_height   <= cfg_wdata_i;
        CfgShoulderOff: len_q.shoulder_off  <= cfg_wdata_i;
        CfgWristTwoOff: len_q.wrist_two_off <= cfg_wdata_i;
        CfgToolOff:     len_q.tool_off      <= cfg_wdata_i;
        CfgUpperArmLen: len_q.upper_arm_len <= cfg_wdata_i;
        CfgForearmLen:  len_q.forearm_len   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Angles for the twelve sine lanes. Sums wrap modulo one turn, and a
  // cosine is the sine a quarter turn ahead.
  logic [AngW-1:0] j [NumJoints];
  logic [AngW-1:0] a23, a234;
  logic [AngW-1:0] lane_ang [NumTrig];

  always_comb begin
    for (int k = 0; k < NumJoints; k++) j[k] = s_axis_tdata[AngW*k +: AngW];
    a23  = j[1] + j[2];
    a234 = a23 + j[3];
    lane_ang[TrigS1]   = j[0];
    lane_ang[TrigC1]   = j[0] + QuarterTurn;
    lane_ang[TrigS2]   = j[1];
    lane_ang[TrigC2]   = j[1] + QuarterTurn;
    lane_ang[TrigS5]   = j[4];
    lane_ang[TrigC5]   = j[4] + QuarterTurn;
    lane_ang[TrigS6]   = j[5];
    lane_ang[TrigC6]   = j[5] + QuarterTurn;
    lane_ang[TrigS23]  = a23;
    lane_ang[TrigC23]  = a23 + QuarterTurn;
    lane_ang[TrigS234] = a234;
    lane_ang[TrigC234] = a234 + QuarterTurn;
  end

  trig_vec_t trig;

  for (genvar g = 0; g < NumTrig; g++) begin : g_lane
    fk_sin_lane u_lane (
      .clk_i   (clk_i),
      .ce_i    (ce),
      .angle_i (lane_ang[g]),
      .sin_o   (trig[g])
    );
  end

  rot_t rot [NumRot];
  pos_t pos [NumPos];

  fk_merge u_merge (
    .clk_i  (clk_i),
    .ce_i   (ce),
    .trig_i (trig),
    .len_i  (len_q),
    .rot_o  (rot),
    .pos_o  (pos)
  );

  assign m_axis_tdata = {6'b0, pos[2], pos[1], pos[0],
                         rot[8], rot[7], rot[6], rot[5], rot[4],
                         rot[3], rot[2], rot[1], rot[0]};

  // The input is held back only by a pose waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting pose");

  // An accepted item enters the first valid stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

  // The first and last rotation entries stay inside the unit range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) >= -16384 &&
                       $signed(m_axis_tdata[15:0]) <= 16384 &&
                       $signed(m_axis_tdata[143:128]) >= -16384 &&
                       $signed(m_axis_tdata[143:128]) <= 16384))
    else $error("rotation entry out of range");

endmodule

/* hw/rtl/fk_sin_lane.sv */
module fk_sin_lane import fk_pkg::*; (
  input  logic            clk_i,
  input  logic            ce_i,
  input  logic [AngW-1:0] angle_i,
  output trig_t           sin_o
);

  logic [14:0] t_d;
  logic [14:0] t_q [7];
  logic        neg_q [8];
  logic [30:0] x2_q [5];
  logic [30:0] p_q [5];
  logic [31:0] r_q;
  trig_t       sin_q;

  logic [29:0] tsq;
  logic [61:0] hprod [5];
  logic [45:0] rprod;
  logic [16:0] rnd;
  logic [14:0] mag;

  // Quadrant folding onto t in [0, 16384].
  always_comb begin
    if (angle_i[14]) begin
      t_d = 15'(15'd16384 - {1'b0, angle_i[13:0]});
    end else begin
      t_d = {1'b0, angle_i[13:0]};
    end
  end

  always_comb begin
    tsq = 30'(t_q[0]) * 30'(t_q[0]);
    for (int h = 0; h < 5; h++) begin
      hprod[h] = x2_q[h] * ((h == 0) ? SinCoef[0] : p_q[(h == 0) ? 0 : h - 1]);
    end
    rprod = t_q[6] * p_q[4];
    rnd   = 17'((r_q + 32'd32768) >> 16);
    mag   = (rnd > 17'd16384) ? 15'd16384 : rnd[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      t_q[0]   <= t_d;
      neg_q[0] <= angle_i[15];
      for (int i = 1; i < 7; i++) t_q[i] <= t_q[i-1];
      for (int i = 1; i < 8; i++) neg_q[i] <= neg_q[i-1];
      // x^2 in Q2.30 with x = t << 16 is exactly t^2 << 2; a quarter turn
      // gives t^2 = 2^28, so bit 28 of the square is kept.
      x2_q[0] <= {tsq[28:0], 2'b00};
      for (int i = 1; i < 5; i++) x2_q[i] <= x2_q[i-1];
      for (int h = 0; h < 5; h++) begin
        p_q[h] <= 31'({1'b0, SinCoef[h+1]} - hprod[h][61:30]);
      end
      r_q   <= rprod[45:14];
      sin_q <= neg_q[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign sin_o = sin_q;

endmodule

/* hw/rtl/fk_merge.sv */
module fk_merge import fk_pkg::*; (
  input  logic      clk_i,
  input  logic      ce_i,
  input  trig_vec_t trig_i,
  input  len_cfg_t  len_i,
  output rot_t      rot_o [NumRot],
  output pos_t      pos_o [NumPos]
);

  typedef logic signed [29:0] pair_t;
  typedef logic signed [59:0] rprod_t;
  typedef logic signed [55:0] pprod_t;

  function automatic pair_t pmul(trig_t a, trig_t b);
    logic signed [31:0] p;
    p = a * b;
    return p[29:0];
  endfunction

  function automatic pair_t pshl(trig_t a);
    return {a, 14'b0};
  endfunction

  function automatic rprod_t rmul(pair_t a, pair_t b);
    rprod_t ax;
    rprod_t bx;
    ax = a;
    bx = b;
    return ax * bx;
  endfunction

  function automatic pprod_t dmul(pair_t a, logic [LenW-1:0] d);
    pprod_t ax;
    pprod_t dx;
    ax = a;
    dx = {36'b0, d};
    return ax * dx;
  endfunction

  function automatic logic signed [43:0] tmul(trig_t a, pair_t b);
    logic signed [43:0] ax;
    logic signed [43:0] bx;
    ax = a;
    bx = b;
    return ax * bx;
  endfunction

  // First stage: two-factor products, single factors scaled to pair width, and joint 1 cosine and sine.
  pair_t cc5_q, sc5_q, c1c6_q, c1s6_q, s1c6_q, s1s6_q, s5c6_q, s5s6_q;
  pair_t s234s6_q, s234c6_q, c234s5_q, s234s5_q;
  pair_t s1u_q, c1u_q, c5u_q, c6u_q, s6u_q, c234u_q, s23u_q, s2u_q;
  pair_t s1c5_q, c1c5_q, c1s234_q, s1s234_q, c1c23_q, s1c23_q, c1c2_q, s1c2_q;
  trig_t c1_q, s1_q;

  // Second stage: rotation terms of up to four factors, triple products, position terms.
  rprod_t rp_d [NumRot][3];
  rprod_t rp_q [NumRot][3];
  pprod_t pp_d [NumPos][5];
  pprod_t pp_q [NumPos][5];
  logic signed [43:0] tc_q, ts_q;

  // Later stages.
  rprod_t rs_q [NumRot];
  logic signed [29:0] trc_q, trs_q;
  pprod_t pa_q [NumPos];
  rot_t   ro_q [NumRot];
  rot_t   ro2_q [NumRot];
  rot_t   ro3_q [NumRot];
  pprod_t qc_q, qs_q;
  pprod_t pa2_q [NumPos];
  pprod_t ps_q [NumPos];
  pos_t   po_q [NumPos];

  logic signed [43:0] tc_rnd, ts_rnd;
  rprod_t rs_rnd [NumRot];
  pprod_t ps_rnd [NumPos];

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      cc5_q    <= pmul(trig_i[TrigC234], trig_i[TrigC5]);
      sc5_q    <= pmul(trig_i[TrigS234], trig_i[TrigC5]);
      c1c6_q   <= pmul(trig_i[TrigC1], trig_i[TrigC6]);
      c1s6_q   <= pmul(trig_i[TrigC1], trig_i[TrigS6]);
      s1c6_q   <= pmul(trig_i[TrigS1], trig_i[TrigC6]);
      s1s6_q   <= pmul(trig_i[TrigS1], trig_i[TrigS6]);
      s5c6_q   <= pmul(trig_i[TrigS5], trig_i[TrigC6]);
      s5s6_q   <= pmul(trig_i[TrigS5], trig_i[TrigS6]);
      s234s6_q <= pmul(trig_i[TrigS234], trig_i[TrigS6]);
      s234c6_q <= pmul(trig_i[TrigS234], trig_i[TrigC6]);
      c234s5_q <= pmul(trig_i[TrigC234], trig_i[TrigS5]);
      s234s5_q <= pmul(trig_i[TrigS234], trig_i[TrigS5]);
      s1c5_q   <= pmul(trig_i[TrigS1], trig_i[TrigC5]);
      c1c5_q   <= pmul(trig_i[TrigC1], trig_i[TrigC5]);
      c1s234_q <= pmul(trig_i[TrigC1], trig_i[TrigS234]);
      s1s234_q <= pmul(trig_i[TrigS1], trig_i[TrigS234]);
      c1c23_q  <= pmul(trig_i[TrigC1], trig_i[TrigC23]);
      s1c23_q  <= pmul(trig_i[TrigS1], trig_i[TrigC23]);
      c1c2_q   <= pmul(trig_i[TrigC1], trig_i[TrigC2]);
      s1c2_q   <= pmul(trig_i[TrigS1], trig_i[TrigC2]);
      s1u_q    <= pshl(trig_i[TrigS1]);
      c1u_q    <= pshl(trig_i[TrigC1]);
      c5u_q    <= pshl(trig_i[TrigC5]);
      c6u_q    <= pshl(trig_i[TrigC6]);
      s6u_q    <= pshl(trig_i[TrigS6]);
      c234u_q  <= pshl(trig_i[TrigC234]);
      s23u_q   <= pshl(trig_i[TrigS23]);
      s2u_q    <= pshl(trig_i[TrigS2]);
      c1_q     <= trig_i[TrigC1];
      s1_q     <= trig_i[TrigS1];
    end
  end

  // Each rotation entry is a signed sum of up to three pair-by-pair products; positions, of five.
  always_comb begin
    rp_d[0][0] =  rmul(cc5_q, c1c6_q);
    rp_d[0][1] =  rmul(s5c6_q, s1u_q);
    rp_d[0][2] = -rmul(s234s6_q, c1u_q);
    rp_d[1][0] = -rmul(cc5_q, c1s6_q);
    rp_d[1][1] = -rmul(s5s6_q, s1u_q);
    rp_d[1][2] = -rmul(s234c6_q, c1u_q);
    rp_d[2][0] = -rmul(c1u_q, c234s5_q);
    rp_d[2][1] =  rmul(s1u_q, c5u_q);
    rp_d[2][2] = '0;
    rp_d[3][0] =  rmul(cc5_q, s1c6_q);
    rp_d[3][1] = -rmul(s5c6_q, c1u_q);
    rp_d[3][2] = -rmul(s234s6_q, s1u_q);
    rp_d[4][0] = -rmul(cc5_q, s1s6_q);
    rp_d[4][1] =  rmul(s5s6_q, c1u_q);
    rp_d[4][2] = -rmul(s234c6_q, s1u_q);
    rp_d[5][0] = -rmul(s1u_q, c234s5_q);
    rp_d[5][1] = -rmul(c1u_q, c5u_q);
    rp_d[5][2] = '0;
    rp_d[6][0] =  rmul(sc5_q, c6u_q);
    rp_d[6][1] =  rmul(c234u_q, s6u_q);
    rp_d[6][2] = '0;
    rp_d[7][0] = -rmul(sc5_q, s6u_q);
    rp_d[7][1] =  rmul(c234u_q, c6u_q);
    rp_d[7][2] = '0;
    rp_d[8][0] = -{{2{s234s5_q[29]}}, s234s5_q, 28'b0};
    rp_d[8][1] = '0;
    rp_d[8][2] = '0;

    pp_d[0][0] =  dmul(s1c5_q, len_i.tool_off);
    pp_d[0][1] =  dmul(c1s234_q, len_i.wrist_two_off);
    pp_d[0][2] = -dmul(c1c23_q, len_i.forearm_len);
    pp_d[0][3] = -dmul(c1c2_q, len_i.upper_arm_len);
    pp_d[0][4] =  dmul(s1u_q, len_i.shoulder_off);
    pp_d[1][0] = -dmul(c1c5_q, len_i.tool_off);
    pp_d[1][1] =  dmul(s1s234_q, len_i.wrist_two_off);
    pp_d[1][2] = -dmul(s1c23_q, len_i.forearm_len);
    pp_d[1][3] = -dmul(s1c2_q, len_i.upper_arm_len);
    pp_d[1][4] = -dmul(c1u_q, len_i.shoulder_off);
    pp_d[2][0] = -dmul(s234s5_q, len_i.tool_off);
    pp_d[2][1] = -dmul(c234u_q, len_i.wrist_two_off);
    pp_d[2][2] = -dmul(s23u_q, len_i.forearm_len);
    pp_d[2][3] = -dmul(s2u_q, len_i.upper_arm_len);
    pp_d[2][4] = {8'b0, len_i.base_height, 28'b0};
  end

  always_comb begin
    tc_rnd = tc_q + 44'sd8192;
    ts_rnd = ts_q + 44'sd8192;
    for (int i = 0; i < NumRot; i++) rs_rnd[i] = rs_q[i] + (60'sd1 <<< 41);
    for (int i = 0; i < NumPos; i++) ps_rnd[i] = ps_q[i] + (56'sd1 <<< 27);
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rp_q <= rp_d;
      pp_q <= pp_d;
      tc_q <= tmul(c1_q, c234s5_q);
      ts_q <= tmul(s1_q, c234s5_q);

      for (int i = 0; i < NumRot; i++) rs_q[i] <= rp_q[i][0] + rp_q[i][1] + rp_q[i][2];
      for (int i = 0; i < NumPos; i++) begin
        pa_q[i] <= pp_q[i][0] + pp_q[i][1] + pp_q[i][2] + pp_q[i][3] + pp_q[i][4];
      end
      trc_q <= tc_rnd[43:14];
      trs_q <= ts_rnd[43:14];

      for (int i = 0; i < NumRot; i++) begin
        if ($signed(rs_rnd[i][59:42]) < -18'sd16384) begin
          ro_q[i] <= -16'sd16384;
        end else if ($signed(rs_rnd[i][59:42]) > 18'sd16384) begin
          ro_q[i] <= 16'sd16384;
        end else begin
          ro_q[i] <= rs_rnd[i][57:42];
        end
      end
      qc_q  <= dmul(trc_q, len_i.tool_off);
      qs_q  <= dmul(trs_q, len_i.tool_off);
      pa2_q <= pa_q;

      ro2_q   <= ro_q;
      ps_q[0] <= pa2_q[0] - qc_q;
      ps_q[1] <= pa2_q[1] - qs_q;
      ps_q[2] <= pa2_q[2];

      ro3_q <= ro2_q;
      for (int i = 0; i < NumPos; i++) begin
        if ($signed(ps_rnd[i][55:28]) < -28'sd2097152) begin
          po_q[i] <= -22'sd2097152;
        end else if ($signed(ps_rnd[i][55:28]) > 28'sd2097151) begin
          po_q[i] <= 22'sd2097151;
        end else begin
          po_q[i] <= ps_rnd[i][49:28];
        end
      end
    end
  end

  assign rot_o = ro3_q;
  assign pos_o = po_q;

endmodule

/* tb/sv/six_axis_arm_forward_kinematics_checker.sv */
module six_axis_arm_forward_kinematics_checker import fk_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  input  logic           s_axis_tvalid,
  input  logic           s_axis_tready,
  // joint1_angle .. joint6_angle, 16 bits each
  input  logic [95:0]    s_axis_tdata,
  input  logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // rot_00 .. rot_22 (16 bits each), pos_x_um, pos_y_um, pos_z_um (22 bits each)
  input  logic [215:0]   m_axis_tdata,
  output int             errors_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Unit = 64'sd16384;

  logic [215:0] pose_queue [$];
  len_cfg_t     links;

  function automatic longint quarter_wave(int unsigned t);
    longint unsigned x, x2, p, r;
    x  = longint'(t) << 16;
    x2 = (x * x) >> 30;
    p  = 64'd3864;
    p  = 64'd172273 - ((x2 * p) >> 30);
    p  = 64'd5026995 - ((x2 * p) >> 30);
    p  = 64'd85569306 - ((x2 * p) >> 30);
    p  = 64'd693598669 - ((x2 * p) >> 30);
    p  = 64'd1686629713 - ((x2 * p) >> 30);
    r  = (x * p) >> 30;
    r  = (r + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return longint'(r);
  endfunction

  function automatic longint angle_sin(logic [15:0] a);
    int unsigned t;
    longint v;
    t = a[14] ? 16384 - a[13:0] : a[13:0];
    v = quarter_wave(t);
    return a[15] ? -v : v;
  endfunction

  function automatic longint angle_cos(logic [15:0] a);
    return angle_sin(a + QuarterTurn);
  endfunction

  // Round half up of v / 2^k.
  function automatic longint round_shift(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic rot_t to_rot(longint q56);
    longint v;
    v = round_shift(q56, 42);
    if (v < -16384) v = -16384;
    if (v > 16384) v = 16384;
    return rot_t'(v);
  endfunction

  function automatic pos_t to_pos(longint q28);
    longint v;
    v = round_shift(q28, 28);
    if (v < -2097152) v = -2097152;
    if (v > 2097151) v = 2097151;
    return pos_t'(v);
  endfunction

  function automatic logic [215:0] predict_pose(logic [95:0] joints, len_cfg_t l);
    logic [15:0] j1, j2, j3, j4, j5, j6, a23, a234;
    longint c1, s1, c2, s2, c5, s5, c6, s6, c23, s23, c234, s234;
    longint d1, d4, d5, d6, la2, la3, cc5, sc5, tx, ty, tz;
    rot_t rot [NumRot];
    pos_t pos [NumPos];
    logic [215:0] packed_pose;
    {j6, j5, j4, j3, j2, j1} = joints;
    a23  = j2 + j3;
    a234 = j2 + j3 + j4;
    c1 = angle_cos(j1);   s1 = angle_sin(j1);
    c2 = angle_cos(j2);   s2 = angle_sin(j2);
    c5 = angle_cos(j5);   s5 = angle_sin(j5);
    c6 = angle_cos(j6);   s6 = angle_sin(j6);
    c23 = angle_cos(a23); s23 = angle_sin(a23);
    c234 = angle_cos(a234); s234 = angle_sin(a234);
    d1 = l.base_height;   d4 = l.shoulder_off;  d5 = l.wrist_two_off;
    d6 = l.tool_off;      la2 = l.upper_arm_len; la3 = l.forearm_len;
    cc5 = c234 * c5;
    sc5 = s234 * c5;
    rot[0] = to_rot(c1 * cc5 * c6 + s1 * s5 * c6 * Unit - c1 * s234 * s6 * Unit);
    rot[1] = to_rot(-c1 * cc5 * s6 - s1 * s5 * s6 * Unit - c1 * s234 * c6 * Unit);
    rot[2] = to_rot(-c1 * c234 * s5 * Unit + s1 * c5 * Unit * Unit);
    rot[3] = to_rot(s1 * cc5 * c6 - c1 * s5 * c6 * Unit - s1 * s234 * s6 * Unit);
    rot[4] = to_rot(-s1 * cc5 * s6 + c1 * s5 * s6 * Unit - s1 * s234 * c6 * Unit);
    rot[5] = to_rot(-s1 * c234 * s5 * Unit - c1 * c5 * Unit * Unit);
    rot[6] = to_rot(sc5 * c6 * Unit + c234 * s6 * Unit * Unit);
    rot[7] = to_rot(-sc5 * s6 * Unit + c234 * c6 * Unit * Unit);
    rot[8] = to_rot(-s234 * s5 * Unit * Unit);
    tx = round_shift(c1 * c234 * s5, 14);
    ty = round_shift(s1 * c234 * s5, 14);
    tz = s234 * s5;
    pos[0] = to_pos(-tx * d6 + s1 * c5 * d6 + c1 * s234 * d5
                    - c1 * c23 * la3 - c1 * c2 * la2 + s1 * d4 * Unit);
    pos[1] = to_pos(-ty * d6 - c1 * c5 * d6 + s1 * s234 * d5
                    - s1 * c23 * la3 - s1 * c2 * la2 - c1 * d4 * Unit);
    pos[2] = to_pos(-tz * d6 - c234 * d5 * Unit - s23 * la3 * Unit
                    - s2 * la2 * Unit + d1 * Unit * Unit);
    packed_pose = '0;
    for (int i = 0; i < NumRot; i++) packed_pose[i*RotW +: RotW] = rot[i];
    for (int i = 0; i < NumPos; i++) packed_pose[NumRot*RotW + i*PosW +: PosW] = pos[i];
    return packed_pose;
  endfunction

  function automatic int field_lsb(int f);
    return f < NumRot ? f * RotW : NumRot * RotW + (f - NumRot) * PosW;
  endfunction

  function automatic int field_width(int f);
    return f < NumRot ? RotW : PosW;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [215:0] want;
    logic [21:0] w, g;
    int wid;
    if (!rst_ni) begin
      links <= '{ResetBaseHeight, ResetShoulderOff, ResetWristTwoOff,
                 ResetToolOff, ResetUpperArmLen, ResetForearmLen};
      errors_o = 0;
      pose_queue.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBaseHeight:  links.base_height   <= cfg_wdata_i;
          CfgShoulderOff: links.shoulder_off  <= cfg_wdata_i;
          CfgWristTwoOff: links.wrist_two_off <= cfg_wdata_i;
          CfgToolOff:     links.tool_off      <= cfg_wdata_i;
          CfgUpperArmLen: links.upper_arm_len <= cfg_wdata_i;
          CfgForearmLen:  links.forearm_len   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pose_queue.push_back(predict_pose(s_axis_tdata, links));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pose_queue.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("Pose out with none expected: %h", m_axis_tdata);
        end else begin
          want = pose_queue.pop_front();
          for (int f = 0; f < NumRot + NumPos; f++) begin
            wid = field_width(f);
            w = '0;
            g = '0;
            for (int b = 0; b < wid; b++) begin
              w[b] = want[field_lsb(f) + b];
              g[b] = m_axis_tdata[field_lsb(f) + b];
            end
            if (w !== g) begin
              errors_o++;
              if (errors_o <= 10) begin
                $display("Pose field %0d mismatch: expected %h, got %h", f, w, g);
              end
            end
          end
        end
      end
      pending_o = pose_queue.size();
    end
  end

endmodule

/* tb/sv/six_axis_arm_forward_kinematics_top_test.sv */
// Stimulus and verdict for the forward kinematics pipeline. The checker beside the
// block predicts every pose and counts mismatches; this module only feeds joint
// vectors, drives the pose-side ready, writes link lengths while the pipeline is
// empty, and decides pass or fail.
module six_axis_arm_forward_kinematics_top_test;
  import fk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that the block has no register for; writes must be ignored.
  localparam logic [2:0] CfgSpareLo = 3'd6;
  localparam logic [2:0] CfgSpareHi = 3'd7;
  localparam logic [LenW-1:0] LenMax = '1;
  localparam int DrainCycles = FkLatency + 5;
  localparam int StallLimit  = 5000;
  localparam int RandomPerPhase = 630;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           cfg_we;
  logic [2:0]     cfg_idx;
  logic [LenW-1:0] cfg_wdata;
  logic           s_tvalid;
  logic           s_tready;
  logic [95:0]    s_tdata;
  logic           m_tvalid;
  logic           m_tready;
  logic [215:0]   m_tdata;
  int             errors;
  int             pending;
  int             tx_idle_pct;
  int             rx_idle_pct;
  int             quiet_cycles;

  always #2 clk_i = ~clk_i;

  six_axis_arm_forward_kinematics_top i_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
  );

  six_axis_arm_forward_kinematics_checker i_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .errors_o(errors), .pending_o(pending)
  );

  // The pose side stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    m_tready <= $urandom_range(99) >= rx_idle_pct;
  end

  // Watchdog: a run with no item moving on either side for too long is hung.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_link(logic [2:0] idx, logic [LenW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all_links(logic [LenW-1:0] l0, l1, l2, l3, l4, l5);
    write_link(CfgBaseHeight, l0);
    write_link(CfgShoulderOff, l1);
    write_link(CfgWristTwoOff, l2);
    write_link(CfgToolOff, l3);
    write_link(CfgUpperArmLen, l4);
    write_link(CfgForearmLen, l5);
    // Spare indexes must leave every length untouched.
    write_link(CfgSpareLo, LenW'($urandom));
    write_link(CfgSpareHi, LenW'($urandom));
  endtask

  // One joint vector; tready is sampled on the falling edge, where it is settled.
  task automatic send_joints(logic [95:0] joints);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= joints;
    do begin
      @(negedge clk_i);
      taken = s_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Valid drops and the task waits on the clock first so that the checker has counted the last item sent.
  task automatic drain_poses();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly uniform angles; now and then a quadrant boundary or its neighbor,
  // where the sine folding and the wrapped sums are most fragile.
  function automatic logic [15:0] pick_angle();
    logic [15:0] edge_angle;
    if ($urandom_range(7) == 0) begin
      edge_angle = 16'($urandom_range(3)) << 14;
      return edge_angle + 16'($urandom_range(2)) - 16'd1;
    end
    return 16'($urandom);
  endfunction

  task automatic send_random(int count);
    logic [95:0] joints;
    for (int n = 0; n < count; n++) begin
      for (int j = 0; j < NumJoints; j++) joints[j*AngW +: AngW] = pick_angle();
      send_joints(joints);
    end
  endtask

  initial begin
    logic [95:0] joints;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CfgBaseHeight;
    cfg_wdata   <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    m_tready    <= 1'b0;
    quiet_cycles <= 0;
    tx_idle_pct = 31;
    rx_idle_pct = 81;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at the reset lengths: all joints at zero, quarter turns,
    // the half turn given as -32768, the largest positive angle, -1, each joint
    // alone just below a quadrant edge, and sums 2+3 and 2+3+4 that wrap.
    send_joints('0);
    send_joints({NumJoints{16'd16384}});
    send_joints({NumJoints{16'h8000}});
    send_joints({NumJoints{16'h7fff}});
    send_joints({NumJoints{16'hffff}});
    send_joints({NumJoints{16'hc000}});
    for (int j = 0; j < NumJoints; j++) begin
      joints = '0;
      joints[j*AngW +: AngW] = 16'd16383;
      send_joints(joints);
    end
    send_joints({16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'd0});
    send_joints({16'h1234, 16'h4321, 16'hc000, 16'h7fff, 16'h7fff, 16'h4000});
    send_joints({16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h4000, 16'hc000});
    send_joints({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa});

    // Phase one: reset lengths, a lazy pose side.
    send_random(RandomPerPhase / 2);
    // The sender holds off until every pose is out, then resumes.
    drain_poses();
    send_random(RandomPerPhase / 2);
    drain_poses();

    // Phase two: all lengths at their maximum, so positions can saturate.
    write_all_links(LenMax, LenMax, LenMax, LenMax, LenMax, LenMax);
    tx_idle_pct = 81;
    rx_idle_pct = 31;
    send_random(RandomPerPhase);
    drain_poses();

    // Phase three: zero lengths, then random ones, with neither side idling.
    write_all_links('0, '0, '0, '0, '0, '0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(RandomPerPhase / 2);
    drain_poses();
    write_all_links(LenW'($urandom), LenW'($urandom), LenW'($urandom),
                    LenW'($urandom), LenW'($urandom), LenW'($urandom));
    send_random(RandomPerPhase / 2);
    drain_poses();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/fk_pkg.sv
hw/rtl/fk_sin_lane.sv
hw/rtl/fk_merge.sv
hw/rtl/six_axis_arm_forward_kinematics_top.sv
tb/sv/six_axis_arm_forward_kinematics_checker.sv
tb/sv/six_axis_arm_forward_kinematics_top_test.sv
